/* rtl/rrs_pkg.sv */
// ----------------------------------------------------------------------------
// RTT running statistics package
// Shared constants, request structs and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

  // Field widths
  localparam int unsigned RttWidth      = 26;
  localparam int unsigned LenWidth      = 16;
  localparam int unsigned HdrWidth      = 4;
  localparam int unsigned MeanOutWidth  = 34;
  localparam int unsigned VarWidth      = 48;
  localparam int unsigned TotalWidth    = 16;

  // Defaults and fixed settings
  localparam int unsigned CountWidth     = 16;
  localparam int unsigned TimestampBytes = 16;
  localparam int unsigned MeanFracBits   = 8;
  localparam int unsigned IcmpHdrBytes   = 8;

  // Payload length check is done on an 18-bit unsigned compare
  localparam int unsigned LenCmpWidth = LenWidth + 2;

  // Fixed-point mean and deviations
  localparam int unsigned MeanWidth = RttWidth + MeanFracBits;

  // Divider: 64-bit dividend, one quotient bit per cycle
  localparam int unsigned DivWidth    = 64;
  localparam int unsigned DivCntWidth = $clog2(DivWidth + 1);

  // Multiplier: four half-by-half partial products
  localparam int unsigned MulHalf      = (MeanWidth + 1) / 2;
  localparam int unsigned MulPadWidth  = 2 * MulHalf;
  localparam int unsigned MulProdWidth = 4 * MulHalf;
  localparam int unsigned MulPhWidth   = 3;

  typedef struct packed {
    logic                   start;
    logic [DivWidth-1:0]    dividend;
    logic [DivCntWidth-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic                 start;
    logic [MeanWidth-1:0] a;
    logic [MeanWidth-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIVM_GO,
    S_DIVM_WAIT,
    S_MEAN,
    S_DNEW,
    S_MUL_GO,
    S_MUL_WAIT,
    S_ACC,
    S_DIVV_GO,
    S_DIVV_WAIT,
    S_VAR,
    S_RESULT
  } rrs_state_e;

endpackage

`default_nettype wire

/* rtl/rrs_divider.sv */
// ----------------------------------------------------------------------------
// RTT statistics divider
// Restoring divider, one quotient bit per cycle, dividend pre-aligned to the
// top of the shift register so a short dividend needs fewer steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_divider #(
  parameter int unsigned COUNT_WIDTH = rrs_pkg::CountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrs_pkg::div_req_t             req_i,
  input  logic [COUNT_WIDTH-1:0]        divisor_i,
  output logic                          done_o,
  output logic [rrs_pkg::DivWidth-1:0]  quotient_o
);
  import rrs_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;
  logic [DivWidth-1:0]    num_q;
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [COUNT_WIDTH-1:0] den_q;

  logic [COUNT_WIDTH:0]   rem_ext;
  logic [COUNT_WIDTH:0]   diff;
  logic                   ge;

  assign rem_ext = {rem_q, num_q[DivWidth-1]};
  assign diff    = rem_ext - {1'b0, den_q};
  assign ge      = rem_ext >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
    end else if (busy_q) begin
      cnt_d = cnt_q - DivCntWidth'(1);
      if (cnt_q == DivCntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // shift one dividend bit into the remainder per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[DivWidth-2:0], ge};
      rem_q <= ge ? diff[COUNT_WIDTH-1:0] : rem_ext[COUNT_WIDTH-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

`default_nettype wire

/* rtl/rrs_multiplier.sv */
// ----------------------------------------------------------------------------
// RTT statistics multiplier
// Multi-cycle product of two deviations from four registered half-width
// partial products, accumulated one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_multiplier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rrs_pkg::mul_req_t                 req_i,
  output logic                              done_o,
  output logic [rrs_pkg::MulProdWidth-1:0]  product_o
);
  import rrs_pkg::*;

  localparam logic [MulPhWidth-1:0] MulSteps = MulPhWidth'(4);

  logic                    busy_q;
  logic                    done_q;
  logic                    pv_q;
  logic [MulPhWidth-1:0]   ph_q;
  logic [MulPadWidth-1:0]  a_q, b_q;
  logic [MulPadWidth-1:0]  pp_q;
  logic [1:0]              psh_q;
  logic [MulProdWidth-1:0] acc_q;

  logic [MulHalf-1:0]      a_part, b_part;
  logic [MulPadWidth-1:0]  pp_d;
  logic [MulProdWidth-1:0] pp_shifted;

  assign a_part = ph_q[0] ? a_q[MulPadWidth-1:MulHalf] : a_q[MulHalf-1:0];
  assign b_part = ph_q[1] ? b_q[MulPadWidth-1:MulHalf] : b_q[MulHalf-1:0];
  assign pp_d   = MulPadWidth'(a_part) * MulPadWidth'(b_part);

  always_comb begin
    case (psh_q)
      2'd0:    pp_shifted = MulProdWidth'(pp_q);
      2'd1:    pp_shifted = MulProdWidth'(pp_q) << MulHalf;
      default: pp_shifted = MulProdWidth'(pp_q) << (2 * MulHalf);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        ph_q   <= '0;
      end else if (busy_q) begin
        pv_q <= (ph_q != MulSteps);
        ph_q <= ph_q + MulPhWidth'(1);
        if (ph_q == MulSteps) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // register each partial product, add it in the cycle after
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= MulPadWidth'(req_i.a);
      b_q   <= MulPadWidth'(req_i.b);
      acc_q <= '0;
    end else if (busy_q) begin
      if (ph_q != MulSteps) begin
        pp_q  <= pp_d;
        psh_q <= 2'(ph_q[0]) + 2'(ph_q[1]);
      end
      if (pv_q) begin
        acc_q <= acc_q + pp_shifted;
      end
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

/* rtl/rtt_running_statistics.sv */
// ----------------------------------------------------------------------------
// RTT running statistics (Welford running mean and variance)
// Sequencing: a duplicate or untimed reply goes from its accepting edge
// straight to the result state; a timed reply first runs the bit-serial mean
// divide, the multiply and the bit-serial variance divide.
// Flow: no new reply is taken while one is in work, and a stalled result word
// holds the next one.
// Reset: asynchronous, active low; clears all statistics and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_running_statistics #(
  parameter int unsigned COUNT_WIDTH = rrs_pkg::CountWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rrs_pkg::LenWidth-1:0]       total_length_i,
  input  logic [rrs_pkg::HdrWidth-1:0]       header_words_i,
  input  logic [rrs_pkg::RttWidth-1:0]       rtt_us_i,
  input  logic                               duplicate_i,

  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               timed_o,
  output logic [rrs_pkg::RttWidth-1:0]       rtt_out_o,
  output logic [rrs_pkg::RttWidth-1:0]       min_rtt_o,
  output logic [rrs_pkg::RttWidth-1:0]       max_rtt_o,
  output logic [rrs_pkg::MeanOutWidth-1:0]   mean_rtt_o,
  output logic [rrs_pkg::VarWidth-1:0]       variance_rtt_o,
  output logic [rrs_pkg::TotalWidth-1:0]     reply_total_o,
  output logic                               was_duplicate_o
);
  import rrs_pkg::*;

  // --------------------------------------------------------------------------
  // Sequencer state and statistics registers
  // --------------------------------------------------------------------------
  rrs_state_e state_q, state_d;

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [RttWidth-1:0]    min_q, max_q;
  logic [MeanWidth-1:0]   mean_q;
  logic [DivWidth-1:0]    ss_q;
  logic [VarWidth-1:0]    var_q;

  // Per-word working registers (no reset)
  logic [RttWidth-1:0]    x_q;
  logic                   dup_q;
  logic                   timed_q;
  logic                   up_q;
  logic [MeanWidth-1:0]   dold_q;
  logic [MeanWidth-1:0]   dnew_q;

  // Result register
  logic                   out_valid_q;
  logic                   res_timed_q;
  logic [RttWidth-1:0]    res_rtt_q;
  logic [RttWidth-1:0]    res_min_q;
  logic [RttWidth-1:0]    res_max_q;
  logic [MeanOutWidth-1:0] res_mean_q;
  logic [VarWidth-1:0]    res_var_q;
  logic [TotalWidth-1:0]  res_total_q;
  logic                   res_dup_q;

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  div_req_t                 div_req;
  logic                     div_done;
  logic [DivWidth-1:0]      div_quot;
  mul_req_t                 mul_req;
  logic                     mul_done;
  logic [MulProdWidth-1:0]  mul_prod;

  rrs_divider #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  rrs_multiplier u_multiplier (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic                    in_acc;
  logic                    len_ok;
  logic                    timed_w;
  logic                    res_load;
  logic [MeanWidth-1:0]    xf;
  logic [MeanWidth-1:0]    quot_mean;
  logic [DivWidth-1:0]     prod_sh;
  logic [DivWidth:0]       ss_sum;

  assign in_acc = in_valid_i && in_ready_o;

  // payload must exceed the timestamp: total - 4*ihl - 8 > TIMESTAMP_BYTES
  assign len_ok = LenCmpWidth'(total_length_i) >
                  (LenCmpWidth'({header_words_i, 2'b00}) +
                   LenCmpWidth'(IcmpHdrBytes + TimestampBytes));
  assign timed_w = !duplicate_i && len_ok;

  // hold the finished word until the output register is free
  assign res_load = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);

  assign xf        = MeanWidth'(x_q) << MeanFracBits;
  assign quot_mean = div_quot[MeanWidth-1:0];
  assign prod_sh   = DivWidth'(mul_prod >> (2 * MeanFracBits));
  assign ss_sum    = {1'b0, ss_q} + {1'b0, prod_sh};

  // count advances on every non-duplicate word, sticks at all ones
  always_comb begin
    count_d = count_q;
    if (in_acc && !duplicate_i && !(&count_q)) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = timed_w ? S_PREP : S_RESULT;
        end
      end
      S_PREP:      state_d = S_DIVM_GO;
      S_DIVM_GO:   state_d = S_DIVM_WAIT;
      S_DIVM_WAIT: begin
        if (div_done) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN:      state_d = S_DNEW;
      S_DNEW:      state_d = S_MUL_GO;
      S_MUL_GO:    state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) begin
          state_d = S_ACC;
        end
      end
      S_ACC:       state_d = S_DIVV_GO;
      S_DIVV_GO:   state_d = S_DIVV_WAIT;
      S_DIVV_WAIT: begin
        if (div_done) begin
          state_d = S_VAR;
        end
      end
      S_VAR:       state_d = S_RESULT;
      S_RESULT: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: handshake and unit requests
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DivWidth'(dold_q) << (DivWidth - MeanWidth);
    div_req.iters    = DivCntWidth'(MeanWidth);
    mul_req.start    = 1'b0;
    mul_req.a        = dold_q;
    mul_req.b        = dnew_q;
    case (state_q)
      S_IDLE:    in_ready_o = 1'b1;
      // mean step: |X - mean| / n, dividend aligned to the top
      S_DIVM_GO: div_req.start = 1'b1;
      S_MUL_GO:  mul_req.start = 1'b1;
      // variance: squares_sum / n over all 64 bits
      S_DIVV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = ss_q;
        div_req.iters    = DivCntWidth'(DivWidth);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Statistics registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      mean_q  <= '0;
      ss_q    <= '0;
      var_q   <= '0;
    end else begin
      count_q <= count_d;
      // min and max move at accept of a timed reply; it sets min when it is the first non-duplicate reply
      if (in_acc && timed_w) begin
        if (rtt_us_i > max_q) begin
          max_q <= rtt_us_i;
        end
        if ((rtt_us_i < min_q) || (count_d == COUNT_WIDTH'(1))) begin
          min_q <= rtt_us_i;
        end
      end
      // Welford step, truncating the step toward the old mean
      if (state_q == S_MEAN) begin
        mean_q <= up_q ? (mean_q + quot_mean) : (mean_q - quot_mean);
      end
      // saturate the sum of squared deviations
      if (state_q == S_ACC) begin
        ss_q <= ss_sum[DivWidth] ? '1 : ss_sum[DivWidth-1:0];
      end
      if (state_q == S_VAR) begin
        var_q <= (|div_quot[DivWidth-1:VarWidth]) ? '1 : div_quot[VarWidth-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Working registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= rtt_us_i;
      dup_q   <= duplicate_i;
      timed_q <= timed_w;
    end
    if (state_q == S_PREP) begin
      up_q   <= xf >= mean_q;
      dold_q <= (xf >= mean_q) ? (xf - mean_q) : (mean_q - xf);
    end
    if (state_q == S_DNEW) begin
      dnew_q <= up_q ? (xf - mean_q) : (mean_q - xf);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_timed_q <= timed_q;
      res_rtt_q   <= timed_q ? x_q : '0;
      res_min_q   <= min_q;
      res_max_q   <= max_q;
      res_mean_q  <= MeanOutWidth'(mean_q);
      res_var_q   <= var_q;
      res_total_q <= TotalWidth'(count_q);
      res_dup_q   <= dup_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign timed_o         = res_timed_q;
  assign rtt_out_o       = res_rtt_q;
  assign min_rtt_o       = res_min_q;
  assign max_rtt_o       = res_max_q;
  assign mean_rtt_o      = res_mean_q;
  assign variance_rtt_o  = res_var_q;
  assign reply_total_o   = res_total_q;
  assign was_duplicate_o = res_dup_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= max_q)
    else $error("min above max");

  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (mean_q <= (MeanWidth'(max_q) << MeanFracBits)))
    else $error("mean above max");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == S_DIVM_WAIT) || (state_q == S_DIVV_WAIT)))
    else $error("divider done outside a wait state");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_RESULT))
    else $error("result word without sequencer result state");
`endif

endmodule

`default_nettype wire
